// ----- rtl/extended_euclid_gcd_defines.svh -----
// Assertion macros for the extended Euclid gcd block
`ifndef EXTENDED_EUCLID_GCD_DEFINES_SVH
`define EXTENDED_EUCLID_GCD_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define EEG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define EEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/eeg_pkg.sv -----
// Package with constants and state type of the extended Euclid gcd block
package eeg_pkg;
    localparam int OPERAND_BITS_DEF = 31;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPDATE,
        ST_DONE
    } t_state;
endpackage

// ----- rtl/eeg_if.sv -----
// Valid/ready channel interface carrying one beat of payload
interface eeg_if #(parameter int W = 8) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/extended_euclid_gcd.sv -----
// Extended Euclid gcd: bit-serial division and coefficient update per quotient step.
// One operand pair is worked on at a time. Each quotient step runs a restoring
// divider that makes one quotient bit per cycle, then a shift-and-add multiply
// that forms q*s1 and q*t1 one quotient bit per cycle, then an update of the
// remainders and coefficients. Up to about 46 steps are needed for 31-bit
// operands; when b is zero no quotient step is run. The result is held in an
// output register; the next pair is accepted once it has been taken.
// Input beat data = {b, a}; output beat data = {coef_b, coef_a, gcd}.
`include "extended_euclid_gcd_defines.svh"
module extended_euclid_gcd #(
    parameter int OPERAND_BITS = eeg_pkg::OPERAND_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    eeg_if.sink   i_in,
    eeg_if.source o_out
);
    import eeg_pkg::*;
    localparam int N  = OPERAND_BITS;
    localparam int C  = OPERAND_BITS + 1;
    localparam int CW = $clog2(OPERAND_BITS + 1);

    t_state r_state, n_state;
    logic [N-1:0]  r_r0, r_r1, r_q, r_rem;
    logic [C-1:0]  r_s0, r_s1, r_t0, r_t1, r_ps, r_pt, r_ms, r_mt;
    logic [CW-1:0] r_cnt;
    logic          r_ovalid;
    logic [N-1:0]  r_ogcd;
    logic [C-1:0]  r_oa, r_ob;

    logic [N:0]   w_trial;
    logic [N:0]   w_sub;
    assign w_trial = {r_rem, r_q[N-1]};
    assign w_sub   = w_trial - {1'b0, r_r1};

    // input ready only when idle and output free
    assign i_in.ready  = (r_state == ST_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = {r_ob, r_oa, r_ogcd};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in.valid && i_in.ready) n_state = ST_CHECK;
            ST_CHECK:  n_state = (r_r1 == '0) ? ST_DONE : ST_DIV;
            ST_DIV:    if (r_cnt == CW'(N - 1)) n_state = ST_MUL;
            ST_MUL:    if (r_cnt == CW'(N - 1)) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_CHECK;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_r0 <= i_in.data[N-1:0];
                r_r1 <= i_in.data[2*N-1:N];
                r_s0 <= C'(1);
                r_t0 <= '0;
                r_s1 <= '0;
                r_t1 <= C'(1);
            end
            ST_CHECK: begin
                // dividend enters quotient register, shifted out msb first
                r_q   <= r_r0;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                if (!w_sub[N]) begin
                    r_rem <= w_sub[N-1:0];
                    r_q   <= {r_q[N-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[N-1:0];
                    r_q   <= {r_q[N-2:0], 1'b0};
                end
                r_cnt <= (r_cnt == CW'(N - 1)) ? '0 : r_cnt + 1'b1;
                r_ps  <= '0;
                r_pt  <= '0;
                r_ms  <= r_s1;
                r_mt  <= r_t1;
            end
            ST_MUL: begin
                // one quotient bit per cycle, lsb first
                if (r_q[0]) begin
                    r_ps <= r_ps + r_ms;
                    r_pt <= r_pt + r_mt;
                end
                r_ms  <= {r_ms[C-2:0], 1'b0};
                r_mt  <= {r_mt[C-2:0], 1'b0};
                r_q   <= {1'b0, r_q[N-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_UPDATE: begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_s0 <= r_s1;
                r_t0 <= r_t1;
                r_s1 <= r_s0 - r_ps;
                r_t1 <= r_t0 - r_pt;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_ogcd <= r_r0;
            r_oa   <= r_s0;
            r_ob   <= r_t0;
        end
    end

    `EEG_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !i_in.ready)
    `EEG_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == ST_DONE, r_ovalid)
    `EEG_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV, r_r1 != '0)
endmodule
